// ===== hw/rtl/gzhpi_pkg.sv =====
package gzhpi_pkg;

    localparam int MAX_PAD_DEF = 32;
    localparam int PAD_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_PAD_SIZE = '0;

    localparam logic [7:0] MAGIC0 = 8'h1f;
    localparam logic [7:0] MAGIC1 = 8'h8b;
    localparam logic [7:0] FLG_FEXTRA = 8'h04;
    localparam logic [7:0] FLG_FHCRC = 8'h02;
    localparam logic [7:0] CHAR_H = 8'h48;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] SUB_HDR_LEN = 8'd4;

    localparam int FB_HCRC = 0;
    localparam int FB_EXTRA = 1;
    localparam int FB_NAME = 2;
    localparam int FB_COMMENT = 3;

    localparam int FIXED_LAST = 5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_GZIP = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [1:0] LVL_EXTRA = 2'd0;
    localparam logic [1:0] LVL_NAME = 2'd1;
    localparam logic [1:0] LVL_COMMENT = 2'd2;

    localparam int PAT_LEN = 5;
    localparam logic [PAT_LEN-1:0][7:0] PATTERN = {8'h31, 8'h76, 8'h62, 8'h74, 8'h68};

    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_CM,
        PH_FLG,
        PH_FIXED,
        PH_XLEN_LO,
        PH_XLEN_HI,
        PH_XDATA,
        PH_NAME,
        PH_COMMENT,
        PH_CRC,
        PH_BODY,
        PH_PASS
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       file_end;
        logic [1:0] status;
    } result_t;

    // what one item turns into: leading bytes, then optionally the subfield
    typedef struct packed {
        logic            valid;
        logic [1:0]      n_pre;
        logic [2:0][7:0] pre_bytes;
        logic [1:0]      pre_status;
        logic            sub;
        logic            trunc;
        logic            last;
    } plan_t;

    function automatic phase_t next_after(input logic [1:0] level, input logic [3:0] flags);
        phase_t ph;
        if (level < LVL_NAME && flags[FB_NAME])
            ph = PH_NAME;
        else if (level < LVL_COMMENT && flags[FB_COMMENT])
            ph = PH_COMMENT;
        else if (flags[FB_HCRC])
            ph = PH_CRC;
        else
            ph = PH_BODY;
        return ph;
    endfunction

endpackage

// ===== hw/rtl/gzhpi_cfg.sv =====
module gzhpi_cfg
    import gzhpi_pkg::*;
#(
    parameter int MAX_PAD = MAX_PAD_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [PAD_W-1:0]  eff_pad
);

    localparam logic [PAD_W-1:0] PAD_CAP = PAD_W'(MAX_PAD);

    logic [PAD_W-1:0] pad_reg;
    logic [PAD_W-1:0] pad_next;

    assign pready = 1'b1;

    always_comb
    begin
        pad_next = pad_reg;
        if (psel && penable && pwrite && paddr == ADDR_PAD_SIZE)
            pad_next = pwdata[PAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_reg <= '0;
        else
            pad_reg <= pad_next;
    end

    assign prdata = (paddr == ADDR_PAD_SIZE) ? DATA_W'(pad_reg) : '0;
    assign eff_pad = (pad_reg > PAD_CAP) ? PAD_CAP : pad_reg;

endmodule

// ===== hw/rtl/gzhpi_parser.sv =====
module gzhpi_parser
    import gzhpi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  item_t            in_data,
    input  logic [PAD_W-1:0] eff_pad,
    input  logic             retire,
    output plan_t            plan
);

    logic        item_valid_reg;
    item_t       item_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [2:0]  hc_reg;
    logic [2:0]  hc_next;
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic [7:0]  old_lo_reg;
    logic [7:0]  old_lo_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic        crc_reg;
    logic        crc_next;

    logic [7:0]  b;
    logic [15:0] old_len;
    logic [16:0] xsum;
    logic [7:0]  fsum;
    logic [15:0] rem_dec;
    logic        accept;

    assign b = item_reg.in_byte;
    assign old_len = {b, old_lo_reg};
    assign xsum = {1'b0, old_len} + 17'(SUB_HDR_LEN) + 17'(eff_pad);
    assign fsum = SUB_HDR_LEN + 8'(eff_pad);
    assign rem_dec = rem_reg - 16'd1;

    assign in_stall = item_valid_reg && !retire;
    assign accept = in_valid && !in_stall;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        hc_next = hc_reg;
        flags_next = flags_reg;
        old_lo_next = old_lo_reg;
        rem_next = rem_reg;
        crc_next = crc_reg;
        unique case (phase_reg)
            PH_MAGIC0:
            begin
                phase_next = (b == MAGIC0) ? PH_MAGIC1 : PH_PASS;
            end
            PH_MAGIC1:
            begin
                phase_next = (b == MAGIC1) ? PH_CM : PH_PASS;
            end
            PH_CM:
            begin
                phase_next = PH_FLG;
            end
            PH_FLG:
            begin
                flags_next = b[4:1];
                hc_next = '0;
                phase_next = PH_FIXED;
            end
            PH_FIXED:
            begin
                if (hc_reg >= 3'(FIXED_LAST))
                begin
                    hc_next = '0;
                    if (flags_reg[FB_EXTRA])
                        phase_next = PH_XLEN_LO;
                    else
                        phase_next = next_after(LVL_EXTRA, flags_reg);
                end
                else
                begin
                    hc_next = hc_reg + 3'd1;
                end
            end
            PH_XLEN_LO:
            begin
                old_lo_next = b;
                phase_next = PH_XLEN_HI;
            end
            PH_XLEN_HI:
            begin
                rem_next = old_len;
                if (old_len == '0)
                    phase_next = next_after(LVL_EXTRA, flags_reg);
                else
                    phase_next = PH_XDATA;
            end
            PH_XDATA:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                    phase_next = next_after(LVL_EXTRA, flags_reg);
            end
            PH_NAME:
            begin
                if (b == '0)
                    phase_next = next_after(LVL_NAME, flags_reg);
            end
            PH_COMMENT:
            begin
                if (b == '0)
                    phase_next = next_after(LVL_COMMENT, flags_reg);
            end
            PH_CRC:
            begin
                crc_next = !crc_reg;
                if (crc_reg)
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                phase_next = PH_BODY;
            end
            default:
            begin
                phase_next = PH_PASS;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        plan.valid = item_valid_reg;
        plan.n_pre = 2'd1;
        plan.pre_bytes = {8'h00, 8'h00, b};
        plan.pre_status = ST_OK;
        plan.sub = 1'b0;
        plan.last = item_reg.in_last;
        plan.trunc = item_reg.in_last && phase_next != PH_BODY && phase_next != PH_PASS;
        unique case (phase_reg)
            PH_MAGIC0:
            begin
                if (b == MAGIC0)
                    plan.n_pre = item_reg.in_last ? 2'd1 : 2'd0;
                else
                    plan.pre_status = ST_NOT_GZIP;
            end
            PH_MAGIC1:
            begin
                plan.n_pre = 2'd2;
                plan.pre_bytes = {8'h00, b, MAGIC0};
                if (b != MAGIC1)
                    plan.pre_status = ST_NOT_GZIP;
            end
            PH_FLG:
            begin
                plan.pre_bytes = {8'h00, 8'h00, (b | FLG_FEXTRA) & ~FLG_FHCRC};
            end
            PH_FIXED:
            begin
                if (hc_reg >= 3'(FIXED_LAST) && !flags_reg[FB_EXTRA])
                begin
                    plan.n_pre = 2'd3;
                    plan.pre_bytes = {8'h00, fsum, b};
                    plan.sub = 1'b1;
                end
            end
            PH_XLEN_LO:
            begin
                plan.n_pre = 2'd0;
            end
            PH_XLEN_HI:
            begin
                plan.n_pre = 2'd2;
                plan.pre_bytes = {8'h00, xsum[15:8], xsum[7:0]};
                plan.pre_status = xsum[16] ? ST_OVERFLOW : ST_OK;
                plan.sub = (old_len == '0);
            end
            PH_XDATA:
            begin
                plan.sub = (rem_dec == '0);
            end
            PH_CRC:
            begin
                plan.n_pre = 2'd0;
            end
            PH_CM, PH_NAME, PH_COMMENT, PH_BODY:
            begin
                plan.n_pre = 2'd1;
            end
            default:
            begin
                plan.pre_status = ST_NOT_GZIP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg <= PH_MAGIC0;
            hc_reg <= '0;
            flags_reg <= '0;
            old_lo_reg <= '0;
            rem_reg <= '0;
            crc_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                item_valid_reg <= 1'b1;
            else if (retire)
                item_valid_reg <= 1'b0;
            if (retire)
            begin
                if (item_reg.in_last)
                begin
                    phase_reg <= PH_MAGIC0;
                    hc_reg <= '0;
                    flags_reg <= '0;
                    old_lo_reg <= '0;
                    rem_reg <= '0;
                    crc_reg <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    hc_reg <= hc_next;
                    flags_reg <= flags_next;
                    old_lo_reg <= old_lo_next;
                    rem_reg <= rem_next;
                    crc_reg <= crc_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
    end

endmodule

// ===== hw/rtl/gzhpi_emitter.sv =====
module gzhpi_emitter
    import gzhpi_pkg::*;
#(
    parameter int MAX_PAD = MAX_PAD_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  plan_t            plan,
    input  logic [PAD_W-1:0] eff_pad,
    output logic             retire,
    output logic             out_valid,
    input  logic             out_stall,
    output result_t          out_data
);

    localparam int CNT_W = $clog2(8 + MAX_PAD);

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [2:0]       pat_reg;
    logic [2:0]       pat_next;
    logic             out_valid_reg;
    result_t          out_reg;

    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] sub_idx;
    logic             has_out;
    logic             advance;
    logic             final_idx;
    logic             in_pre;
    logic             pat_bump;
    result_t          res;

    assign total = CNT_W'(plan.n_pre)
        + (plan.sub ? (CNT_W'(SUB_HDR_LEN) + CNT_W'(eff_pad)) : '0);
    assign has_out = plan.valid && total != '0;
    assign advance = !out_valid_reg || !out_stall;
    assign final_idx = (idx_reg == total - CNT_W'(1));
    assign retire = plan.valid && (total == '0 || (advance && final_idx));
    assign in_pre = idx_reg < CNT_W'(plan.n_pre);
    assign sub_idx = idx_reg - CNT_W'(plan.n_pre);
    assign pat_bump = !in_pre && sub_idx >= CNT_W'(SUB_HDR_LEN);

    always_comb
    begin
        res.run_end = final_idx;
        res.file_end = final_idx && plan.last;
        res.status = ST_OK;
        res.out_byte = PATTERN[pat_reg];
        if (in_pre)
        begin
            res.status = plan.pre_status;
            unique case (idx_reg[1:0])
                2'd0: res.out_byte = plan.pre_bytes[0];
                2'd1: res.out_byte = plan.pre_bytes[1];
                2'd2: res.out_byte = plan.pre_bytes[2];
                default: res.out_byte = plan.pre_bytes[0];
            endcase
        end
        else if (sub_idx == CNT_W'(0))
        begin
            res.out_byte = CHAR_H;
        end
        else if (sub_idx == CNT_W'(1))
        begin
            res.out_byte = CHAR_T;
        end
        else if (sub_idx == CNT_W'(2))
        begin
            res.out_byte = 8'(eff_pad);
        end
        else if (sub_idx == CNT_W'(3))
        begin
            res.out_byte = 8'h00;
        end
        if (plan.trunc)
            res.status = ST_TRUNC;
    end

    always_comb
    begin
        idx_next = idx_reg;
        pat_next = pat_reg;
        if (advance && has_out)
        begin
            if (final_idx)
            begin
                idx_next = '0;
                pat_next = '0;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
                if (pat_bump)
                    pat_next = (pat_reg == 3'(PAT_LEN - 1)) ? 3'd0 : pat_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            pat_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            pat_reg <= pat_next;
            if (advance)
                out_valid_reg <= has_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_out)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

// ===== hw/rtl/gzip_header_padding_inserter_core.sv =====
// an accepted byte is registered in the parser, its result bytes in the emitter
// throughput: one result byte per cycle; body bytes flow at one per cycle while out_stall is low
// a header byte that expands into n result bytes (n up to 7 + MAX_PAD) stalls the input
// until its last result byte is loaded into the single output byte register
// reset: rst_n async active low, parser back to first magic byte, pad_size 0
module gzip_header_padding_inserter_core
    import gzhpi_pkg::*;
#(
    parameter int MAX_PAD = MAX_PAD_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  item_t             in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output result_t           out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [PAD_W-1:0] eff_pad;
    logic             retire;
    plan_t            plan;

    gzhpi_cfg #(
        .MAX_PAD(MAX_PAD)
    ) u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .eff_pad(eff_pad)
    );

    gzhpi_parser u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .eff_pad(eff_pad),
        .retire(retire),
        .plan(plan)
    );

    gzhpi_emitter #(
        .MAX_PAD(MAX_PAD)
    ) u_emitter (
        .clk(clk),
        .rst_n(rst_n),
        .plan(plan),
        .eff_pad(eff_pad),
        .retire(retire),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

endmodule
